// ----- hw/rtl/sc2a_pkg.sv -----
// Package for the scan code set 1 to ASCII decoder.
// Holds scan code constants, the two character tables and the key class helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sc2a_pkg;

  // Scan code bytes and make codes of interest (low seven bits)
  localparam logic [7:0] PrefixByte = 8'hE0;
  localparam logic [6:0] McCtrl     = 7'h1D;
  localparam logic [6:0] McAlt      = 7'h38;
  localparam logic [6:0] McShiftL   = 7'h2A;
  localparam logic [6:0] McShiftR   = 7'h36;
  localparam logic [6:0] McCaps     = 7'h3A;
  localparam logic [7:0] TableEnd   = 8'h3B;

  // Characters for the ctrl rule: the base letter and the two letters it rewrites
  localparam logic [6:0] ChLowerA = 7'h61;
  localparam logic [6:0] ChLowerL = 7'h6C;
  localparam logic [6:0] ChLowerU = 7'h75;

  localparam int unsigned IdxW = 6;

  // Plain column, indexed by make code; entries past the key set are zero
  localparam logic [6:0] PlainCol [2**IdxW] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Shifted column, same indexing
  localparam logic [6:0] ShiftCol [2**IdxW] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Digit and punctuation keys follow shift alone, not caps lock.
  function automatic logic is_symbol_key(input logic [6:0] code);
    logic result;
    result = (code < 7'h0E) || (code == 7'h1A) || (code == 7'h1B) ||
             (code == 7'h27) || (code == 7'h28) || (code == 7'h29) ||
             (code == 7'h2B) || (code == 7'h33) || (code == 7'h34) ||
             (code == 7'h35);
    return result;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scancode_to_ascii_decoder.sv -----
// Scan code set 1 to ASCII decoder, top level.
// Depends on sc2a_pkg for the scan code constants and character tables.
//
// Usage:
// - Input stream: one raw keyboard byte per item on s_axis_tdata.
// - Output stream: exactly one result item per input item, in order.
//   tdata carries the ASCII code (zero when no character), tuser carries
//   the char_valid and unknown_code flags.
// - Pipeline: an accepted byte is held in one input register, then decoded
//   into the result register once that register is free or being taken:
//   one input register, then the decode into the result register.
// - Throughput is one item per cycle while m_axis_tready stays high. The
//   modifier and prefix flags are read and updated in the same cycle that an
//   item moves from the input register to the result register, so
//   back-to-back bytes see each other's effect without a bubble.
// - When the receiver stalls, the result register holds, the input
//   register fills, and s_axis_tready drops until the result is taken.
// - Reset clears both pipeline valids and all flags (prefix, ctrl, alt,
//   shift, caps lock).
`timescale 1ns / 1ps
`default_nettype none

module scancode_to_ascii_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input items
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] scan_byte
  // Result items
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [6:0] char_code, [7] zero
  output logic [1:0]      m_axis_tuser    // [0] char_valid, [1] unknown_code
);

  import sc2a_pkg::*;

  // Pipeline registers
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       out_char_valid_q;
  logic [6:0] out_char_code_q;
  logic       out_unknown_q;

  // Keyboard state flags
  logic prefix_q, prefix_d;
  logic ctrl_q, ctrl_d;
  logic alt_q, alt_d;
  logic shift_q, shift_d;
  logic caps_q, caps_d;

  // Decode results
  logic       res_char_valid;
  logic [6:0] res_char_code;
  logic       res_unknown;

  logic            advance;
  logic [6:0]      code7;
  logic            in_table;
  logic            use_shift;
  logic [IdxW-1:0] idx;
  logic [6:0]      ch;

  // Handshake: the input register moves on when the result register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Table lookup for the byte in the input register
  assign code7     = in_byte_q[6:0];
  assign idx       = in_byte_q[IdxW-1:0];
  assign in_table  = prefix_q ? ((code7 == McCtrl) || (code7 == McAlt))
                              : ((in_byte_q != 8'h00) && (in_byte_q < TableEnd));
  assign use_shift = (!prefix_q && is_symbol_key(code7)) ? shift_q : (shift_q ^ caps_q);
  assign ch        = use_shift ? ShiftCol[idx] : PlainCol[idx];

  // Decode and next flag values
  always_comb begin
    prefix_d       = prefix_q;
    ctrl_d         = ctrl_q;
    alt_d          = alt_q;
    shift_d        = shift_q;
    caps_d         = caps_q;
    res_char_valid = 1'b0;
    res_char_code  = '0;
    res_unknown    = 1'b0;
    if (in_byte_q == PrefixByte) begin
      prefix_d = 1'b1;
    end else begin
      prefix_d = 1'b0;
      if (in_byte_q[7]) begin
        // Break code: release modifiers; extended breaks never clear shift
        if (code7 == McCtrl) ctrl_d = 1'b0;
        if (code7 == McAlt) alt_d = 1'b0;
        if (!prefix_q && ((code7 == McShiftL) || (code7 == McShiftR))) shift_d = 1'b0;
      end else if (in_table) begin
        if (ch != 7'h00) begin
          res_char_valid = 1'b1;
          res_char_code  = (ctrl_q && ((ch == ChLowerL) || (ch == ChLowerU)))
                           ? (ch - ChLowerA) : ch;
        end else begin
          // Modifier make codes
          priority if (code7 == McCtrl) begin
            ctrl_d = 1'b1;
          end else if (code7 == McAlt) begin
            alt_d = 1'b1;
          end else if ((code7 == McShiftL) || (code7 == McShiftR)) begin
            shift_d = 1'b1;
          end else if (code7 == McCaps) begin
            caps_d = !caps_q;
          end else begin
            caps_d = caps_q;
          end
        end
      end else begin
        res_unknown = 1'b1;
      end
    end
  end

  // Control state: pipeline valids and keyboard flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prefix_q    <= 1'b0;
      ctrl_q      <= 1'b0;
      alt_q       <= 1'b0;
      shift_q     <= 1'b0;
      caps_q      <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        prefix_q    <= prefix_d;
        ctrl_q      <= ctrl_d;
        alt_q       <= alt_d;
        shift_q     <= shift_d;
        caps_q      <= caps_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_char_valid_q <= res_char_valid;
      out_char_code_q  <= res_char_code;
      out_unknown_q    <= res_unknown;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_code_q};
  assign m_axis_tuser  = {out_unknown_q, out_char_valid_q};

  // A result never claims both a character and an unknown code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("char_valid and unknown_code both set");

  // Without a character, the code field is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'h00))
    else $error("char_code nonzero without char_valid");

  // A prefix byte that moves through arms the extended flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_byte_q == PrefixByte)) |=> prefix_q)
    else $error("prefix byte did not arm the extended flag");

  // A stalled input item stays in its register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled input item lost");

endmodule

`default_nettype wire
